@@ rtl/core/spi_flash_quad_read_slave_macros.svh @@
// Assertion helpers shared by the flash slave RTL.
`ifndef SPI_FLASH_QUAD_READ_SLAVE_MACROS_SVH
`define SPI_FLASH_QUAD_READ_SLAVE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SFQR_ASSERT_NOW(name, clk_sig, rst_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SFQR_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sfqr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sfqr_pkg;

    // item actions
    localparam logic [1:0] ACT_EDGE       = 2'd0;
    localparam logic [1:0] ACT_CS_RELEASE = 2'd1;
    localparam logic [1:0] ACT_PRELOAD    = 2'd2;

    // command set
    localparam logic [7:0] CMD_QUAD_READ_4B   = 8'hEC;
    localparam logic [7:0] CMD_WRITE_ANY_REG  = 8'h71;
    localparam logic [7:0] CMD_QUAD_READ      = 8'hEB;
    localparam logic [7:0] CMD_RDID           = 8'h9F;
    localparam logic [7:0] CMD_READ_CR        = 8'h35;
    localparam logic [7:0] CMD_WRITE_ENABLE   = 8'h06;
    localparam logic [7:0] CMD_READ_SECURITY  = 8'h48;
    localparam logic [7:0] CMD_READ_SR        = 8'h05;
    localparam logic [7:0] CMD_SECTOR_ERASE   = 8'h20;
    localparam logic [7:0] CMD_PAGE_PROGRAM   = 8'h02;

    localparam logic [23:0] CR1_REG_ADDR = 24'h800002;
    localparam logic [7:0]  FILL_BYTE    = 8'h57;

    // bit counter landmarks
    localparam logic [5:0] BC_CMD_START = 6'd8;
    localparam logic [5:0] BC_ADDR_DONE = 6'd32;
    localparam logic [5:0] BC_FETCH     = 6'd40;
    localparam logic [5:0] BC_WRAP      = 6'd48;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  data_lines;
        logic [15:0] load_address;
        logic [7:0]  load_byte;
    } sfqr_item_t;

    typedef struct packed {
        logic       drive_valid;
        logic [3:0] drive_nibble;
        logic       out_of_range;
        logic       unknown_command;
        logic [7:0] cr1_value;
    } sfqr_result_t;

    // what the output stage does with its data word
    typedef enum logic [1:0] {
        OP_IDLE,
        OP_EMIT,
        OP_FETCH,
        OP_SEED
    } sfqr_op_t;

    typedef struct packed {
        sfqr_op_t    op;
        logic        out_of_range;
        logic        unknown_command;
        logic [7:0]  cr1_value;
        logic [31:0] seed_word;
    } sfqr_ctl_t;

    function automatic logic is_known(input logic [7:0] code);
        return code inside {CMD_RDID, CMD_READ_CR, CMD_WRITE_ENABLE, CMD_READ_SECURITY,
                            CMD_WRITE_ANY_REG, CMD_READ_SR, CMD_SECTOR_ERASE,
                            CMD_PAGE_PROGRAM, CMD_QUAD_READ, CMD_QUAD_READ_4B};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sfqr_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfqr_store #(
    parameter int ADDR_BITS = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_en,
    input  wire [ADDR_BITS-1:0]  wr_addr,
    input  wire [7:0]            wr_data,
    input  wire                  rd_en,
    input  wire [ADDR_BITS-1:0]  rd_addr,
    output logic [7:0]           rd_data,
    output logic                 clearing
);
    import sfqr_pkg::*;

    localparam int unsigned DEPTH = 1 << ADDR_BITS;

    logic [7:0]           mem [0:DEPTH-1];
    logic [7:0]           rd_data_reg;
    logic                 clr_busy_reg;
    logic [ADDR_BITS-1:0] clr_addr_reg;

    // fill pass after reset, one byte per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= FILL_BYTE;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_busy_reg;

endmodule

`default_nettype wire

@@ rtl/core/sfqr_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfqr_seq #(
    parameter int ADDR_BITS = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         accept,
    input  wire sfqr_pkg::sfqr_item_t   item,
    output logic                        rd_en,
    output logic [ADDR_BITS-1:0]        rd_addr,
    output logic                        wr_en,
    output logic [ADDR_BITS-1:0]        wr_addr,
    output logic [7:0]                  wr_data,
    output sfqr_pkg::sfqr_ctl_t         ctl
);
    import sfqr_pkg::*;

    logic [31:0] shift_word_reg, shift_word_next;
    logic [5:0]  bit_count_reg, bit_count_next;
    logic [7:0]  command_reg, command_next;
    logic        awaiting_reg, awaiting_next;
    logic        quad_reg, quad_next;
    logic        read_phase_reg, read_phase_next;
    logic [31:0] read_addr_reg, read_addr_next;
    logic [7:0]  cr1_reg, cr1_next;

    logic        restart;
    logic        quad_now;
    logic [5:0]  bc_step;
    logic [31:0] load_addr_ext;

    assign load_addr_ext = {16'd0, item.load_address};
    assign wr_addr       = load_addr_ext[ADDR_BITS-1:0];
    assign wr_data       = item.load_byte;

    always_comb
    begin
        shift_word_next = shift_word_reg;
        bit_count_next  = bit_count_reg;
        command_next    = command_reg;
        awaiting_next   = awaiting_reg;
        quad_next       = quad_reg;
        read_phase_next = read_phase_reg;
        read_addr_next  = read_addr_reg;
        cr1_next        = cr1_reg;
        restart         = 1'b0;
        quad_now        = quad_reg;
        bc_step         = bit_count_reg + 6'd4;
        rd_en           = 1'b0;
        rd_addr         = read_addr_reg[ADDR_BITS-1:0];
        wr_en           = 1'b0;
        ctl             = '0;
        ctl.op          = OP_IDLE;

        if (accept)
        begin
            case (item.action)
                ACT_EDGE:
                begin
                    if (awaiting_reg)
                    begin
                        shift_word_next = {shift_word_reg[30:0], item.data_lines[0]};
                        bit_count_next  = bit_count_reg - 6'd1;
                        if (bit_count_next == 6'd0)
                        begin
                            awaiting_next = 1'b0;
                            command_next  = shift_word_next[7:0];
                            if (!is_known(shift_word_next[7:0]))
                            begin
                                ctl.unknown_command = 1'b1;
                                restart             = 1'b1;
                            end
                        end
                    end
                    else if (command_reg == CMD_QUAD_READ_4B ||
                             command_reg == CMD_WRITE_ANY_REG)
                    begin
                        quad_now  = quad_reg ||
                                    (command_reg == CMD_QUAD_READ_4B && bit_count_reg == 6'd0);
                        quad_next = quad_now;
                        if (quad_now)
                        begin
                            if (!read_phase_reg)
                            begin
                                shift_word_next = {shift_word_reg[27:0], item.data_lines};
                            end
                            bit_count_next = (bc_step == BC_WRAP) ? BC_FETCH : bc_step;
                        end
                        else
                        begin
                            if (!read_phase_reg)
                            begin
                                shift_word_next = {shift_word_reg[30:0], item.data_lines[0]};
                            end
                            bit_count_next = bit_count_reg + 6'd1;
                        end

                        if (command_reg == CMD_QUAD_READ_4B)
                        begin
                            if (bit_count_next == BC_ADDR_DONE)
                            begin
                                read_addr_next = shift_word_next;
                            end
                            if (bit_count_next == BC_FETCH)
                            begin
                                read_phase_next = 1'b1;
                            end
                            if (bit_count_next >= BC_FETCH && bit_count_next[2:0] == 3'd0)
                            begin
                                if ((read_addr_next >> ADDR_BITS) == 32'd0)
                                begin
                                    rd_en          = 1'b1;
                                    rd_addr        = read_addr_next[ADDR_BITS-1:0];
                                    read_addr_next = read_addr_next + 32'd1;
                                    ctl.op         = OP_FETCH;
                                end
                                else
                                begin
                                    // first fetch out of range: the shift word is seeded
                                    // into the output shifter, leaks out on later edges
                                    ctl.out_of_range = 1'b1;
                                    ctl.op           = read_phase_reg ? OP_IDLE : OP_SEED;
                                end
                            end
                            else if (read_phase_next)
                            begin
                                ctl.op = OP_EMIT;
                            end
                        end
                        else if (bit_count_next == BC_ADDR_DONE)
                        begin
                            if (shift_word_next[31:8] == CR1_REG_ADDR)
                            begin
                                cr1_next = shift_word_next[7:0];
                            end
                            restart = 1'b1;
                        end
                    end
                end
                ACT_CS_RELEASE:
                begin
                    restart = 1'b1;
                end
                ACT_PRELOAD:
                begin
                    wr_en = ((load_addr_ext >> ADDR_BITS) == 32'd0);
                end
                default:
                begin
                end
            endcase

            if (restart)
            begin
                awaiting_next   = 1'b1;
                bit_count_next  = BC_CMD_START;
                quad_next       = 1'b0;
                read_phase_next = 1'b0;
            end
        end

        ctl.cr1_value = cr1_next;
        ctl.seed_word = shift_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_word_reg <= '0;
            bit_count_reg  <= BC_CMD_START;
            command_reg    <= '0;
            awaiting_reg   <= 1'b1;
            quad_reg       <= 1'b0;
            read_phase_reg <= 1'b0;
            read_addr_reg  <= '0;
            cr1_reg        <= '0;
        end
        else
        begin
            shift_word_reg <= shift_word_next;
            bit_count_reg  <= bit_count_next;
            command_reg    <= command_next;
            awaiting_reg   <= awaiting_next;
            quad_reg       <= quad_next;
            read_phase_reg <= read_phase_next;
            read_addr_reg  <= read_addr_next;
            cr1_reg        <= cr1_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sfqr_out.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfqr_out (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         take,
    input  wire sfqr_pkg::sfqr_ctl_t    ctl_in,
    input  wire [7:0]                   rd_data,
    input  wire                         result_stall,
    output logic                        ready,
    output logic                        result_valid,
    output sfqr_pkg::sfqr_result_t      result
);
    import sfqr_pkg::*;

    logic         s2_valid_reg;
    sfqr_ctl_t    s2_ctl_reg;
    logic [31:0]  word_reg, word_next;
    logic         res_valid_reg;
    sfqr_result_t res_reg, res_next;

    logic         s2_adv;
    logic         drive;
    logic [31:0]  src;

    assign s2_adv = s2_valid_reg && (!res_valid_reg || !result_stall);
    assign ready  = !s2_valid_reg || s2_adv;

    always_comb
    begin
        drive = s2_ctl_reg.op inside {OP_EMIT, OP_FETCH};
        src   = (s2_ctl_reg.op == OP_FETCH) ? {24'd0, rd_data} : word_reg;

        res_next.drive_valid     = drive;
        res_next.drive_nibble    = drive ? src[7:4] : 4'd0;
        res_next.out_of_range    = s2_ctl_reg.out_of_range;
        res_next.unknown_command = s2_ctl_reg.unknown_command;
        res_next.cr1_value       = s2_ctl_reg.cr1_value;

        case (s2_ctl_reg.op)
            OP_EMIT, OP_FETCH: word_next = {src[27:0], 4'd0};
            OP_SEED:           word_next = s2_ctl_reg.seed_word;
            default:           word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_ctl_reg <= ctl_in;
        end
        if (s2_adv)
        begin
            word_reg <= word_next;
            res_reg  <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

@@ rtl/core/spi_flash_quad_read_slave.sv @@
// Quad-I/O serial NOR flash slave, one serial clock edge (or chip-select release, or store
// preload) per item. An item is accepted every clock unless item_stall is high; its result
// passes through the stage-2 register into the output register, and one more item is taken
// while a result is held by a stall. The command sequencer advances its state only on
// accepted items, and the store is a single synchronous RAM with one write and one read
// port that is read once per fetched byte. After reset the store is filled with 0x57 by a
// pass over every address, during which item_stall stays high.
`timescale 1ns / 1ps
`default_nettype none
`include "spi_flash_quad_read_slave_macros.svh"

module spi_flash_quad_read_slave #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         item_valid,
    output logic                        item_stall,
    input  wire sfqr_pkg::sfqr_item_t   item,
    output logic                        result_valid,
    input  wire                         result_stall,
    output sfqr_pkg::sfqr_result_t      result
);
    import sfqr_pkg::*;

    logic                     accept;
    logic                     ready;
    logic                     clearing;
    logic                     rd_en;
    logic [MEM_ADDR_BITS-1:0] rd_addr;
    logic                     wr_en;
    logic [MEM_ADDR_BITS-1:0] wr_addr;
    logic [7:0]               wr_data;
    logic [7:0]               rd_data;
    sfqr_ctl_t                ctl;
    logic                     edge_take;
    logic                     flag_drive;

    assign item_stall = clearing || !ready;
    assign accept     = item_valid && !item_stall;

    sfqr_seq #(
        .ADDR_BITS (MEM_ADDR_BITS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .ctl     (ctl)
    );

    sfqr_store #(
        .ADDR_BITS (MEM_ADDR_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    sfqr_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (accept),
        .ctl_in       (ctl),
        .rd_data      (rd_data),
        .result_stall (result_stall),
        .ready        (ready),
        .result_valid (result_valid),
        .result       (result)
    );

    assign edge_take  = accept && (item.action == ACT_EDGE);
    assign flag_drive = result.drive_valid && (result.out_of_range || result.unknown_command);

    `SFQR_ASSERT_NOW(a_idle_while_clearing, clk, rst_n, clearing, !result_valid, "early result")
    `SFQR_ASSERT_NEXT(a_fill_done_once, clk, rst_n, !clearing, !clearing, "fill restarted")
    `SFQR_ASSERT_NOW(a_fetch_on_edge, clk, rst_n, rd_en, edge_take, "read without edge")
    `SFQR_ASSERT_NOW(a_no_drive_on_flag, clk, rst_n, result_valid, !flag_drive, "flagged drive")

endmodule

`default_nettype wire
